// ----- hdl/ect_pkg.sv -----
// shared types and constants for the entity change tracker
package ect_pkg;

    localparam int ENTITY_W    = 6;
    localparam int COORD_W     = 32;
    localparam int THRESH_W    = 31;
    localparam int MARK_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd6;

    // mark bit positions
    localparam int MARK_SPAWNED   = 0;
    localparam int MARK_DESTROYED = 1;
    localparam int MARK_MOVED     = 2;

    typedef enum logic [1:0] {
        OP_SPAWN   = 2'd0,
        OP_DESTROY = 2'd1,
        OP_TRACK   = 2'd2,
        OP_CONSUME = 2'd3
    } ect_op_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] rot;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } xform_t;

    typedef struct packed {
        ect_op_t             op;
        logic [ENTITY_W-1:0] entity;
        xform_t              xform;
    } cmd_t;

    typedef struct packed {
        logic                entry_valid;
        logic [ENTITY_W-1:0] entity;
        logic                spawned;
        logic                destroyed;
        logic                moved;
        logic                has_xform;
        xform_t              xform;
        logic                last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SCAN,
        ST_FETCH,
        ST_FLUSH
    } bk_state_t;

endpackage

// ----- hdl/ect_if.sv -----
// channel interfaces: event input, threshold write, drain report output
interface ect_evt_if;
    import ect_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [ENTITY_W-1:0]        entity_id;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  rotation;
    logic signed [COORD_W-1:0]  scale_x;
    logic signed [COORD_W-1:0]  scale_y;

    modport source (
        output valid, func, entity_id, pos_x, pos_y, rotation, scale_x, scale_y,
        input  ready
    );
    modport sink (
        input  valid, func, entity_id, pos_x, pos_y, rotation, scale_x, scale_y,
        output ready
    );
endinterface

interface ect_cfg_if;
    import ect_pkg::*;
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] move_threshold;

    modport source (output valid, move_threshold, input ready);
    modport sink (input valid, move_threshold, output ready);
endinterface

interface ect_rpt_if;
    import ect_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      entry_valid;
    logic [ENTITY_W-1:0]       out_entity;
    logic                      was_spawned;
    logic                      was_destroyed;
    logic                      was_moved;
    logic                      has_transform;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_rotation;
    logic signed [COORD_W-1:0] out_scale_x;
    logic signed [COORD_W-1:0] out_scale_y;
    logic                      last;

    modport source (
        output valid, entry_valid, out_entity, was_spawned, was_destroyed, was_moved,
               has_transform, out_x, out_y, out_rotation, out_scale_x, out_scale_y,
               last,
        input  ready
    );
    modport sink (
        input  valid, entry_valid, out_entity, was_spawned, was_destroyed, was_moved,
               has_transform, out_x, out_y, out_rotation, out_scale_x, out_scale_y,
               last,
        output ready
    );
endinterface

// ----- hdl/ect_front.sv -----
// front end: accepts event items, decodes them and drops out-of-range events
module ect_front #(
    parameter int ENTITY_COUNT = 64
) (
    ect_evt_if.sink        evt,
    input  logic           q_full,
    output logic           push,
    output ect_pkg::cmd_t  push_data
);
    import ect_pkg::*;

    localparam logic [ENTITY_W:0] COUNT_EXT = (ENTITY_W+1)'(ENTITY_COUNT);

    logic    accept;
    logic    in_range;
    ect_op_t op;

    // accept whenever the queue has room
    assign evt.ready = !q_full;
    assign accept    = evt.valid && evt.ready;

    // classify: consume always goes on, other events only for existing entities
    assign op       = ect_op_t'(evt.func);
    assign in_range = {1'b0, evt.entity_id} < COUNT_EXT;
    assign push     = accept && ((op == OP_CONSUME) || in_range);

    // command for the back end
    always_comb
    begin
        push_data.op       = op;
        push_data.entity   = evt.entity_id;
        push_data.xform.x  = evt.pos_x;
        push_data.xform.y  = evt.pos_y;
        push_data.xform.rot = evt.rotation;
        push_data.xform.sx = evt.scale_x;
        push_data.xform.sy = evt.scale_y;
    end

endmodule

// ----- hdl/ect_queue.sv -----
// short command queue between the front and back ends
module ect_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ect_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ect_pkg::cmd_t  head
);
    import ect_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/ect_back.sv -----
// back end: mark table, transform memory, movement test and drain sequencer
module ect_back #(
    parameter int ENTITY_COUNT = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ect_pkg::cmd_t  q_head,
    output logic           q_pop,
    ect_cfg_if.sink        cfg,
    ect_rpt_if.source      report
);
    import ect_pkg::*;

    localparam int IDX_W = $clog2(ENTITY_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTITY_COUNT - 1);

    bk_state_t state_reg, state_next;
    cmd_t      cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [THRESH_W-1:0] thr_reg;

    logic [ENTITY_COUNT-1:0][MARK_W-1:0] marks_reg, marks_next;
    logic [ENTITY_COUNT-1:0]             present_reg, present_next;

    xform_t mem [ENTITY_COUNT];
    xform_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    xform_t           wr_data;

    logic [MARK_W-1:0] fmark_reg, fmark_next;
    logic              fpres_reg, fpres_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic              out_load;
    logic              out_free;
    logic              moved;
    logic [IDX_W-1:0]  ev_idx;
    logic [IDX_W-1:0]  cur_idx;
    result_t           fetched;
    result_t           empty_res;

    // absolute 33-bit difference above threshold
    function automatic logic differs(input logic [COORD_W-1:0] s,
                                     input logic [COORD_W-1:0] f,
                                     input logic [THRESH_W-1:0] thr);
        logic [COORD_W:0] d;
        logic [COORD_W:0] mag;
        d   = {f[COORD_W-1], f} - {s[COORD_W-1], s};
        mag = d[COORD_W] ? ((COORD_W+1)'(0) - d) : d;
        return mag > {2'b00, thr};
    endfunction

    assign out_free = !out_valid_reg || report.ready;
    assign ev_idx   = q_head.entity[IDX_W-1:0];
    assign cur_idx  = cur_reg.entity[IDX_W-1:0];

    // movement test against the stored transform
    assign moved = differs(rd_data_reg.x,   cur_reg.xform.x,   thr_reg)
                || differs(rd_data_reg.y,   cur_reg.xform.y,   thr_reg)
                || differs(rd_data_reg.rot, cur_reg.xform.rot, thr_reg)
                || differs(rd_data_reg.sx,  cur_reg.xform.sx,  thr_reg)
                || differs(rd_data_reg.sy,  cur_reg.xform.sy,  thr_reg);

    // result built from the entry just fetched
    always_comb
    begin
        fetched.entry_valid = 1'b1;
        fetched.entity      = ENTITY_W'(idx_reg);
        fetched.spawned     = fmark_reg[MARK_SPAWNED];
        fetched.destroyed   = fmark_reg[MARK_DESTROYED];
        fetched.moved       = fmark_reg[MARK_MOVED];
        fetched.has_xform   = fpres_reg;
        fetched.xform       = fpres_reg ? rd_data_reg : '0;
        fetched.last        = 1'b0;
        empty_res           = '0;
        empty_res.last      = 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        marks_next      = marks_reg;
        present_next    = present_reg;
        fmark_next      = fmark_reg;
        fpres_next      = fpres_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_next        = out_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = ev_idx;
        wr_en           = 1'b0;
        wr_addr         = ev_idx;
        wr_data         = q_head.xform;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_SPAWN:
                        begin
                            marks_next[ev_idx][MARK_SPAWNED] = 1'b1;
                            present_next[ev_idx] = 1'b1;
                            wr_en = 1'b1;
                        end
                        OP_DESTROY:
                        begin
                            marks_next[ev_idx][MARK_DESTROYED] = 1'b1;
                            present_next[ev_idx] = 1'b0;
                        end
                        OP_TRACK:
                        begin
                            if (!present_reg[ev_idx])
                            begin
                                present_next[ev_idx] = 1'b1;
                                wr_en = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                cur_next   = q_head;
                                state_next = ST_CMP;
                            end
                        end
                        default:
                        begin
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_CMP:
            begin
                if (moved)
                begin
                    marks_next[cur_idx][MARK_MOVED] = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = cur_idx;
                    wr_data = cur_reg.xform;
                end
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                rd_addr = idx_reg;
                if (marks_reg[idx_reg] != '0)
                begin
                    rd_en      = 1'b1;
                    fmark_next = marks_reg[idx_reg];
                    fpres_next = present_reg[idx_reg];
                    state_next = ST_FETCH;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_FETCH:
            begin
                // hold one result back so the final one can carry last
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load = 1'b1;
                        out_next = pend_reg;
                    end
                    pend_next       = fetched;
                    pend_valid_next = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next = empty_res;
                    end
                    marks_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (report.ready ? 1'b0 : out_valid_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            marks_reg      <= '0;
            present_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= THRESH_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            marks_reg      <= marks_next;
            present_reg    <= present_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.move_threshold;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        fmark_reg <= fmark_next;
        fpres_reg <= fpres_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    // transform memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // threshold port never stalls
    assign cfg.ready = 1'b1;

    // report channel
    assign report.valid         = out_valid_reg;
    assign report.entry_valid   = out_reg.entry_valid;
    assign report.out_entity    = out_reg.entity;
    assign report.was_spawned   = out_reg.spawned;
    assign report.was_destroyed = out_reg.destroyed;
    assign report.was_moved     = out_reg.moved;
    assign report.has_transform = out_reg.has_xform;
    assign report.out_x         = out_reg.xform.x;
    assign report.out_y         = out_reg.xform.y;
    assign report.out_rotation  = out_reg.xform.rot;
    assign report.out_scale_x   = out_reg.xform.sx;
    assign report.out_scale_y   = out_reg.xform.sy;
    assign report.last          = out_reg.last;

    // empty drain item always closes the drain
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && !report.entry_valid |-> report.last)
        else $error("empty drain item without last");

    // no stored transform means zero transform fields
    a_no_xform_zero: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid && !report.has_transform |->
            report.out_x == '0 && report.out_y == '0 && report.out_rotation == '0
            && report.out_scale_x == '0 && report.out_scale_y == '0)
        else $error("transform fields nonzero without stored transform");

    // compare step only follows a track read issued from idle
    a_cmp_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> $past(state_reg) == ST_IDLE)
        else $error("compare step entered from wrong state");

    // finishing a drain leaves every mark clear
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH && out_free |=> marks_reg == '0)
        else $error("marks not cleared after drain");

    // a held-back result only exists during a drain
    a_pend_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |->
            state_reg == ST_SCAN || state_reg == ST_FETCH || state_reg == ST_FLUSH)
        else $error("held-back result outside a drain");

endmodule

// ----- hdl/entity_change_tracker_core.sv -----
// top level of the entity change tracker
//
// Keeps spawned/destroyed/moved marks and the last reported transform for
// each of ENTITY_COUNT entities. Event items arrive on evt (func, entity_id,
// five Q16.16 transform values); the movement threshold is written on cfg.
// Spawn, destroy and track items give no report. A consume item drains
// every marked entity in ascending order on report, the final item flagged
// with last, then clears all marks; with nothing marked one item with
// entry_valid low and last high is sent.
// Events pass through a two-item queue into the table sequencer. Spawn,
// destroy and a first track are handled in the idle state; a track with a
// stored transform goes on to a registered read of the transform memory,
// then the compare and write back. A consume scans the whole table: the
// sequencer visits one table entry per cycle unless the report is stalled,
// and adds a memory read for each marked entry. Each result is held back
// one step so the final one can carry last; the first report item leaves
// once the next marked entry is fetched or the scan ends.
// Reset clears all marks and presence bits and sets the threshold to 6; no
// clearing pass is needed. If report is stalled the sequencer holds one
// result back and then waits; the queue fills and evt.ready drops.
module entity_change_tracker_core #(
    parameter int ENTITY_COUNT = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ect_evt_if.sink   evt,
    ect_cfg_if.sink   cfg,
    ect_rpt_if.source report
);
    import ect_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_data;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    // decode and filter incoming events
    ect_front #(
        .ENTITY_COUNT(ENTITY_COUNT)
    ) u_front (
        .evt       (evt),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    ect_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // table update and drain
    ect_back #(
        .ENTITY_COUNT(ENTITY_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .report  (report)
    );

endmodule
